>>> design/fat16_chain_table_generator_macros.svh
// assertion macros for the fat16 chain table generator controller
// no dependencies; included by fctg_ctrl, the module that carries checks
`ifndef FAT16_CHAIN_TABLE_GENERATOR_MACROS_SVH
`define FAT16_CHAIN_TABLE_GENERATOR_MACROS_SVH

// same-cycle implication under synchronous reset
`define FCTG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fctg check failed");

// next-cycle implication under synchronous reset
`define FCTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fctg check failed");

`endif

>>> design/fctg_pkg.sv
// shared constants, command codes and controller command type
// used by fctg_ctrl, fctg_datapath and the top level
`default_nettype none

package fctg_pkg;

    // layout sizing
    localparam int NUM_FILES     = 8;
    localparam int CLUSTER_BYTES = 2048;  // power of two
    localparam int CLUSTER_SHIFT = $clog2(CLUSTER_BYTES);
    localparam int SLOT_IW       = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;

    // field widths
    localparam int CMD_W   = 2;
    localparam int SIZE_W  = 32;
    localparam int CLUS_W  = 16;
    localparam int SLOTS_W = 4;

    // stream word widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PLACE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // table entry codes
    localparam logic [CLUS_W-1:0] FAT_BAD    = 16'hFFF7;
    localparam logic [CLUS_W-1:0] FAT_MEDIA  = 16'hFFF8;
    localparam logic [CLUS_W-1:0] FAT_EOC    = 16'hFFFF;
    localparam logic [CLUS_W-1:0] FIRST_DATA = 16'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming word
        logic execute;  // update layout state and load the result register
    } t_ctrl_cmd;

endpackage

`default_nettype wire

>>> design/fctg_ctrl.sv
// handshake controller: input capture, execute slot and result valid flag
// depends on fctg_pkg and the assertion macro header
`default_nettype none
`include "fat16_chain_table_generator_macros.svh"

module fctg_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    output fctg_pkg::t_ctrl_cmd   o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic w_out_free;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    o_cmd.execute = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.execute) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `FCTG_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, 1'b1, !(o_cmd.capture && o_cmd.execute))
    `FCTG_ASSERT_NOW(a_exec_free, i_clk, i_rst_n, o_cmd.execute, (!r_out_valid || i_m_tready))
    `FCTG_ASSERT_NEXT(a_exec_valid, i_clk, i_rst_n, o_cmd.execute, r_out_valid)
    `FCTG_ASSERT_NEXT(a_capture_exec, i_clk, i_rst_n, o_cmd.capture, (r_state == S_EXEC))

endmodule

`default_nettype wire

>>> design/fctg_datapath.sv
// layout state, cluster allocation, table entry lookup and result register
// depends on fctg_pkg; driven by fctg_ctrl commands
`default_nettype none

module fctg_datapath (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  fctg_pkg::t_ctrl_cmd                  i_cmd,
    input  wire [fctg_pkg::CMD_W-1:0]            i_command,
    input  wire                                  i_file_valid,
    input  wire [fctg_pkg::SIZE_W-1:0]           i_file_size,
    input  wire [fctg_pkg::CLUS_W-1:0]           i_entry_index,
    output logic [fctg_pkg::CLUS_W-1:0]          o_fat_entry,
    output logic [fctg_pkg::CLUS_W-1:0]          o_file_start,
    output logic [fctg_pkg::CLUS_W-1:0]          o_file_end,
    output logic [fctg_pkg::CLUS_W-1:0]          o_disk_end,
    output logic                                 o_slot_overflow
);

    localparam int CW = fctg_pkg::CLUS_W;

    // captured item
    logic [fctg_pkg::CMD_W-1:0]  r_command;
    logic                        r_file_valid;
    logic [fctg_pkg::SIZE_W-1:0] r_file_size;
    logic [CW-1:0]               r_entry_index;

    // layout state
    logic [CW-1:0]                r_next_cluster;
    logic [fctg_pkg::SLOTS_W-1:0] r_slots_used;
    logic [CW-1:0]                r_end_store [fctg_pkg::NUM_FILES];

    // next values
    logic [CW-1:0] n_fat_entry;
    logic [CW-1:0] n_file_start;
    logic [CW-1:0] n_file_end;
    logic [CW-1:0] n_disk_end;
    logic          n_slot_overflow;

    logic [fctg_pkg::SIZE_W:0] w_round;
    logic [CW-1:0]             w_clusters;
    logic [CW-1:0]             w_next_ptr;
    logic [CW-1:0]             w_last;
    logic                      w_full;
    logic [CW-1:0]             w_base;
    logic                      w_end_hit;
    logic [fctg_pkg::SLOT_IW-1:0] w_slot;

    // ceiling divide by a power-of-two cluster size
    assign w_round    = {1'b0, r_file_size} + (fctg_pkg::SIZE_W+1)'(fctg_pkg::CLUSTER_BYTES - 1);
    assign w_clusters = CW'(w_round >> fctg_pkg::CLUSTER_SHIFT);
    assign w_next_ptr = r_next_cluster + w_clusters;
    assign w_last     = w_next_ptr - CW'(1);
    assign w_full     = (r_slots_used >= fctg_pkg::SLOTS_W'(fctg_pkg::NUM_FILES));
    assign w_slot     = r_slots_used[fctg_pkg::SLOT_IW-1:0];
    assign w_base     = {r_entry_index[CW-1:8], 8'h00};

    always_comb begin
        w_end_hit = 1'b0;
        for (int i = 0; i < fctg_pkg::NUM_FILES; i++) begin
            if (r_end_store[i] == r_entry_index) begin
                w_end_hit = 1'b1;
            end
        end
    end

    always_comb begin
        n_fat_entry     = '0;
        n_file_start    = '0;
        n_file_end      = '0;
        n_disk_end      = r_next_cluster;
        n_slot_overflow = 1'b0;
        unique case (r_command)
            fctg_pkg::CMD_START: begin
                n_disk_end = fctg_pkg::FIRST_DATA;
            end
            fctg_pkg::CMD_PLACE: begin
                if (w_full) begin
                    n_slot_overflow = 1'b1;
                end else if (r_file_valid) begin
                    n_file_start = r_next_cluster;
                    n_file_end   = w_last;
                    n_disk_end   = w_next_ptr;
                end else begin
                    n_file_start = fctg_pkg::FAT_EOC;
                    n_file_end   = fctg_pkg::FAT_EOC;
                end
            end
            fctg_pkg::CMD_READ: begin
                if (w_base >= r_next_cluster) begin
                    n_fat_entry = fctg_pkg::FAT_BAD;
                end else if (r_entry_index == '0) begin
                    n_fat_entry = fctg_pkg::FAT_MEDIA;
                end else if (r_entry_index == CW'(1)) begin
                    n_fat_entry = fctg_pkg::FAT_EOC;
                end else if (r_entry_index >= r_next_cluster) begin
                    n_fat_entry = fctg_pkg::FAT_BAD;
                end else if (w_end_hit) begin
                    n_fat_entry = fctg_pkg::FAT_EOC;
                end else begin
                    n_fat_entry = r_entry_index + CW'(1);
                end
            end
            default: ;
        endcase
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command     <= i_command;
            r_file_valid  <= i_file_valid;
            r_file_size   <= i_file_size;
            r_entry_index <= i_entry_index;
        end
    end

    // layout state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.execute && r_command == fctg_pkg::CMD_START)) begin
            r_next_cluster <= fctg_pkg::FIRST_DATA;
            r_slots_used   <= '0;
            for (int i = 0; i < fctg_pkg::NUM_FILES; i++) begin
                r_end_store[i] <= fctg_pkg::FAT_EOC;
            end
        end else if (i_cmd.execute && r_command == fctg_pkg::CMD_PLACE && !w_full) begin
            r_slots_used <= r_slots_used + fctg_pkg::SLOTS_W'(1);
            if (r_file_valid) begin
                r_next_cluster      <= w_next_ptr;
                r_end_store[w_slot] <= w_last;
            end else begin
                r_end_store[w_slot] <= fctg_pkg::FAT_EOC;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            o_fat_entry     <= n_fat_entry;
            o_file_start    <= n_file_start;
            o_file_end      <= n_file_end;
            o_disk_end      <= n_disk_end;
            o_slot_overflow <= n_slot_overflow;
        end
    end

endmodule

`default_nettype wire

>>> design/fat16_chain_table_generator.sv
// top level of the fat16 chain table generator
// depends on fctg_pkg, fctg_ctrl and fctg_datapath
//
// usage
//   slave stream carries commands: tuser holds the command code (start layout,
//   place next file slot, read table entry); tdata holds the file flag, file
//   size and table entry index. master stream returns exactly one word per
//   command with the table entry, file start and end clusters, the first free
//   cluster after the command and the slot overflow flag.
// timing
//   a command is captured into the input register at its accepting edge and the
//   controller moves to the execute state, where it waits until the output
//   register is free and then executes, loading the result word; a new command
//   is taken only once the last one has executed. the next command is taken
//   while a result still waits in the output register. the read lookup compares
//   the entry against all stored end clusters in parallel in the execute cycle.
// reset
//   synchronous active-low reset empties the output, sets the first free
//   cluster to 2 and marks every file slot unused; a start command does the
//   same to the layout.
// backpressure
//   while the master side stalls the result holds; one further command is
//   captured and then waits in the execute state until the output frees up.
`default_nettype none

module fat16_chain_table_generator (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // slave side
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: file_valid[0], file_size[32:1], entry_index[48:33], zero pad [55:49]
    input  wire [fctg_pkg::S_TDATA_W-1:0]       i_s_tdata,
    // tuser: command[1:0]
    input  wire [fctg_pkg::CMD_W-1:0]           i_s_tuser,
    // master side
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    // tdata: fat_entry[15:0], file_start[31:16], file_end[47:32],
    //        disk_end[63:48], slot_overflow[64], zero pad [71:65]
    output logic [fctg_pkg::M_TDATA_W-1:0]      o_m_tdata
);

    fctg_pkg::t_ctrl_cmd w_cmd;

    logic [fctg_pkg::CLUS_W-1:0] w_fat_entry;
    logic [fctg_pkg::CLUS_W-1:0] w_file_start;
    logic [fctg_pkg::CLUS_W-1:0] w_file_end;
    logic [fctg_pkg::CLUS_W-1:0] w_disk_end;
    logic                        w_slot_overflow;

    // handshake and sequencing
    fctg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    // layout state and result computation
    fctg_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_command       (i_s_tuser),
        .i_file_valid    (i_s_tdata[0]),
        .i_file_size     (i_s_tdata[32:1]),
        .i_entry_index   (i_s_tdata[48:33]),
        .o_fat_entry     (w_fat_entry),
        .o_file_start    (w_file_start),
        .o_file_end      (w_file_end),
        .o_disk_end      (w_disk_end),
        .o_slot_overflow (w_slot_overflow)
    );

    // pack the result word, lowest field first
    assign o_m_tdata = {7'd0, w_slot_overflow, w_disk_end, w_file_end,
                        w_file_start, w_fat_entry};

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// self-checking testbench for the fat16 chain table generator
// depends on fctg_pkg and the fat16_chain_table_generator rtl
// directed table first, then random command streams checked by an in-bench layout model
`timescale 1ns / 1ps

module testbench;

    // command code the block does not know; it must leave the layout alone
    localparam logic [fctg_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int RANDOM_WORDS = 630;

    typedef struct packed {
        logic [fctg_pkg::CMD_W-1:0]  cmd;
        logic                        file_valid;
        logic [fctg_pkg::SIZE_W-1:0] file_size;
        logic [fctg_pkg::CLUS_W-1:0] entry_index;
    } t_cmd_word;

    typedef struct packed {
        logic [fctg_pkg::CLUS_W-1:0] fat_entry;
        logic [fctg_pkg::CLUS_W-1:0] file_start;
        logic [fctg_pkg::CLUS_W-1:0] file_end;
        logic [fctg_pkg::CLUS_W-1:0] disk_end;
        logic                        slot_overflow;
    } t_result_word;

    // one directed stimulus row; typed rows carry their own answer
    typedef struct packed {
        t_cmd_word    word;
        logic         typed;
        t_result_word answer;
    } t_directed_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [fctg_pkg::S_TDATA_W-1:0] i_s_tdata = '0;  // file_valid, file_size, entry_index, pad
    logic [fctg_pkg::CMD_W-1:0]     i_s_tuser = '0;  // command
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [fctg_pkg::M_TDATA_W-1:0] o_m_tdata;  // fat_entry, file_start, file_end, disk_end, ovf

    fat16_chain_table_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // layout model state
    logic [fctg_pkg::CLUS_W-1:0]  next_free;
    logic [fctg_pkg::SLOTS_W-1:0] slots_filled;
    logic [fctg_pkg::CLUS_W-1:0]  last_cluster [fctg_pkg::NUM_FILES];

    t_result_word  pending_results [$];  // expected result words, oldest first
    t_directed_row offered_rows [$];     // words handed to the bus, not yet taken
    t_directed_row directed_tbl [24];
    int            mismatches = 0;

    function automatic void clear_layout_model();
        next_free = fctg_pkg::FIRST_DATA;
        slots_filled = '0;
        for (int i = 0; i < fctg_pkg::NUM_FILES; i++) last_cluster[i] = fctg_pkg::FAT_EOC;
    endfunction

    // value of one table entry for the current layout
    function automatic logic [fctg_pkg::CLUS_W-1:0] chain_entry(
        input logic [fctg_pkg::CLUS_W-1:0] idx);
        logic [fctg_pkg::CLUS_W-1:0] sector_base;
        sector_base = {idx[fctg_pkg::CLUS_W-1:8], 8'h00};
        // whole sector lies past the placed files
        if (sector_base >= next_free) return fctg_pkg::FAT_BAD;
        if (idx == 16'd0) return fctg_pkg::FAT_MEDIA;
        if (idx == 16'd1) return fctg_pkg::FAT_EOC;
        if (idx >= next_free) return fctg_pkg::FAT_BAD;
        for (int i = 0; i < fctg_pkg::NUM_FILES; i++)
            if (last_cluster[i] == idx) return fctg_pkg::FAT_EOC;
        return idx + 16'd1;
    endfunction

    // apply one command to the layout model and return the result word it yields
    function automatic t_result_word advance_layout(input t_cmd_word w);
        t_result_word r;
        logic [fctg_pkg::SIZE_W:0]   clusters;
        logic [fctg_pkg::CLUS_W-1:0] new_next;
        r = '0;
        case (w.cmd)
            fctg_pkg::CMD_START: clear_layout_model();
            fctg_pkg::CMD_PLACE: begin
                if (slots_filled >= fctg_pkg::NUM_FILES) begin
                    r.slot_overflow = 1'b1;
                end else begin
                    if (w.file_valid) begin
                        // 33 bits so the rounding add cannot carry out
                        clusters = ({1'b0, w.file_size} + fctg_pkg::CLUSTER_BYTES - 1)
                                   >> fctg_pkg::CLUSTER_SHIFT;
                        new_next = next_free + clusters[fctg_pkg::CLUS_W-1:0];
                        r.file_start = next_free;
                        r.file_end = new_next - 16'd1;  // empty file ends one before it starts
                        next_free = new_next;
                    end else begin
                        r.file_start = fctg_pkg::FAT_EOC;
                        r.file_end = fctg_pkg::FAT_EOC;
                    end
                    last_cluster[slots_filled[fctg_pkg::SLOT_IW-1:0]] = r.file_end;
                    slots_filled = slots_filled + 1'b1;
                end
            end
            fctg_pkg::CMD_READ: r.fat_entry = chain_entry(w.entry_index);
            default: ;
        endcase
        r.disk_end = next_free;
        return r;
    endfunction

    function automatic t_directed_row dir_row(input logic [fctg_pkg::CMD_W-1:0] cmd,
                                              input logic valid,
                                              input logic [31:0] size, input logic [15:0] idx,
                                              input logic typed, input logic [15:0] fat,
                                              input logic [15:0] fstart, input logic [15:0] fend,
                                              input logic [15:0] dend, input logic ovf);
        t_directed_row d;
        d.word = '{cmd, valid, size, idx};
        d.typed = typed;
        d.answer = '{fat, fstart, fend, dend, ovf};
        return d;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // input side: every accepted command word runs through the layout model
    always @(posedge i_clk) begin : watch_commands
        t_cmd_word     w;
        t_directed_row row;
        t_result_word  predicted;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            w.cmd = i_s_tuser;
            w.file_valid = i_s_tdata[0];
            w.file_size = i_s_tdata[32:1];
            w.entry_index = i_s_tdata[48:33];
            predicted = advance_layout(w);
            row = offered_rows.pop_front();
            pending_results.push_back(row.typed ? row.answer : predicted);
        end
    end

    // output side: each result word against the oldest expectation
    always @(posedge i_clk) begin : watch_results
        t_result_word got;
        t_result_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tdata[15:0], o_m_tdata[31:16], o_m_tdata[47:32],
                    o_m_tdata[63:48], o_m_tdata[64]};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", got.fat_entry, 16'h0000);
            end else begin
                want = pending_results.pop_front();
                if (got.fat_entry != want.fat_entry)
                    report_mismatch("fat_entry", got.fat_entry, want.fat_entry);
                if (got.file_start != want.file_start)
                    report_mismatch("file_start", got.file_start, want.file_start);
                if (got.file_end != want.file_end)
                    report_mismatch("file_end", got.file_end, want.file_end);
                if (got.disk_end != want.disk_end)
                    report_mismatch("disk_end", got.disk_end, want.disk_end);
                if (got.slot_overflow != want.slot_overflow)
                    report_mismatch("slot_overflow", {15'd0, got.slot_overflow},
                                    {15'd0, want.slot_overflow});
            end
        end
    end

    // receiver: switches among always ready, coin flip, sparse and very sparse
    logic [1:0] rx_mode = 2'd0;
    int         rx_hold = 0;
    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            rx_mode <= 2'($urandom_range(0, 3));
            rx_hold <= $urandom_range(16, 80);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            2'd0: i_m_tready <= 1'b1;
            2'd1: i_m_tready <= 1'($urandom_range(0, 1));
            2'd2: i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // put one word on the slave side and hold it until the handshake
    task automatic send_word(input t_directed_row row);
        offered_rows.push_back(row);
        i_s_tvalid <= 1'b1;
        i_s_tuser <= row.word.cmd;
        i_s_tdata <= {7'd0, row.word.entry_index, row.word.file_size, row.word.file_valid};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    int burst_left = 0;

    // bursts of random length, random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // generous fixed limit
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        t_directed_row row;
        int            sel;
        int            kind;
        clear_layout_model();

        // reset state reads, then a file run through empty, one, exact and one-over sizes
        directed_tbl[0]  = dir_row(fctg_pkg::CMD_READ, 0, 32'h0, 16'h0000, 1,
                                   fctg_pkg::FAT_MEDIA, 0, 0, 2, 0);
        directed_tbl[1]  = dir_row(fctg_pkg::CMD_READ, 0, 32'h0, 16'h0001, 1,
                                   fctg_pkg::FAT_EOC, 0, 0, 2, 0);
        directed_tbl[2]  = dir_row(fctg_pkg::CMD_READ, 0, 32'h0, 16'h0002, 1,
                                   fctg_pkg::FAT_BAD, 0, 0, 2, 0);
        directed_tbl[3]  = dir_row(fctg_pkg::CMD_READ, 1, 32'hFFFF_FFFF, 16'hFFFF, 1,
                                   fctg_pkg::FAT_BAD, 0, 0, 2, 0);
        directed_tbl[4]  = dir_row(CMD_NONE, 1, 32'hFFFF_FFFF, 16'hFFFF, 1, 0, 0, 0, 2, 0);
        directed_tbl[5]  = dir_row(fctg_pkg::CMD_PLACE, 1, 32'd0,    16'h0, 1, 0, 2, 1, 2, 0);
        directed_tbl[6]  = dir_row(fctg_pkg::CMD_PLACE, 1, 32'd1,    16'h0, 1, 0, 2, 2, 3, 0);
        directed_tbl[7]  = dir_row(fctg_pkg::CMD_PLACE, 1, 32'd2048, 16'h0, 1, 0, 3, 3, 4, 0);
        directed_tbl[8]  = dir_row(fctg_pkg::CMD_PLACE, 1, 32'd2049, 16'h0, 1, 0, 4, 5, 6, 0);
        directed_tbl[9]  = dir_row(fctg_pkg::CMD_PLACE, 0, 32'hFFFF_FFFF, 16'hFFFF, 1,
                                   0, fctg_pkg::FAT_EOC, fctg_pkg::FAT_EOC, 6, 0);
        directed_tbl[10] = dir_row(fctg_pkg::CMD_READ, 0, 32'h0, 16'h0002, 0, 0, 0, 0, 0, 0);
        directed_tbl[11] = dir_row(fctg_pkg::CMD_READ, 0, 32'h0, 16'h0004, 0, 0, 0, 0, 0, 0);
        directed_tbl[12] = dir_row(fctg_pkg::CMD_READ, 0, 32'h0, 16'h0005, 0, 0, 0, 0, 0, 0);
        // largest size, then a size that runs the pointer up to the top and one that wraps it
        directed_tbl[13] = dir_row(fctg_pkg::CMD_PLACE, 1, 32'hFFFF_FFFF, 16'h0,
                                   0, 0, 0, 0, 0, 0);
        directed_tbl[14] = dir_row(fctg_pkg::CMD_PLACE, 1, 32'h07FF_8000, 16'h0,
                                   0, 0, 0, 0, 0, 0);
        directed_tbl[15] = dir_row(fctg_pkg::CMD_PLACE, 1, 32'h0001_0000, 16'h0,
                                   0, 0, 0, 0, 0, 0);
        // all slots used
        directed_tbl[16] = dir_row(fctg_pkg::CMD_PLACE, 1, 32'h800, 16'h0,
                                   1, 0, 0, 0, 16'h0016, 1);
        directed_tbl[17] = dir_row(fctg_pkg::CMD_READ, 0, 32'h0, 16'h0015, 0, 0, 0, 0, 0, 0);
        directed_tbl[18] = dir_row(fctg_pkg::CMD_READ, 0, 32'h0, 16'hFFF5, 0, 0, 0, 0, 0, 0);
        directed_tbl[19] = dir_row(fctg_pkg::CMD_START, 1, 32'hFFFF_FFFF, 16'hFFFF,
                                   1, 0, 0, 0, 2, 0);
        // layout past one sector, so the sector gate and the per-entry gate differ
        directed_tbl[20] = dir_row(fctg_pkg::CMD_PLACE, 1, 32'h0010_0000, 16'h0,
                                   0, 0, 0, 0, 0, 0);
        directed_tbl[21] = dir_row(fctg_pkg::CMD_READ, 0, 32'h0, 16'h01FF, 0, 0, 0, 0, 0, 0);
        directed_tbl[22] = dir_row(fctg_pkg::CMD_READ, 0, 32'h0, 16'h02FF, 0, 0, 0, 0, 0, 0);
        directed_tbl[23] = dir_row(fctg_pkg::CMD_READ, 0, 32'h0, 16'h0201, 0, 0, 0, 0, 0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 24; i++) begin
            send_word(directed_tbl[i]);
            pace_sender();
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // hold off once until the block has drained
            if (n == RANDOM_WORDS / 2) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending_results.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            row = '0;
            row.word.file_valid = 1'($urandom);
            row.word.file_size = $urandom;
            row.word.entry_index = 16'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < 5) begin
                row.word.cmd = fctg_pkg::CMD_START;
            end else if (sel < 10) begin
                row.word.cmd = CMD_NONE;
            end else if (sel < 45) begin
                row.word.cmd = fctg_pkg::CMD_PLACE;
                row.word.file_valid = ($urandom_range(0, 5) != 0);
                kind = $urandom_range(0, 9);
                case (kind)
                    0: row.word.file_size = 32'd0;
                    1: ;  // full range, wraps the pointer
                    2: row.word.file_size = fctg_pkg::CLUSTER_BYTES * $urandom_range(1, 8)
                                            + $urandom_range(0, 2) - 1;
                    3: row.word.file_size = 32'hFFFF_FFFF - $urandom_range(0, 4095);
                    default: row.word.file_size = $urandom_range(1, 65536);
                endcase
            end else begin
                row.word.cmd = fctg_pkg::CMD_READ;
                kind = $urandom_range(0, 9);
                case (kind)
                    0, 1: ;  // anywhere in the table
                    2: row.word.entry_index =
                           last_cluster[$urandom_range(0, fctg_pkg::NUM_FILES - 1)]
                           + 16'($urandom_range(0, 2)) - 16'd1;
                    3: row.word.entry_index = next_free + 16'($urandom_range(0, 2)) - 16'd1;
                    4: row.word.entry_index = 16'($urandom_range(0, 1));
                    default: row.word.entry_index = 16'($urandom_range(0, next_free));
                endcase
            end
            send_word(row);
            pace_sender();
        end

        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
